// ----- rtl/core/bfha_pkg.sv -----
// Package: sizes, status codes and word types for the best-fit heap allocator.
`default_nettype none
package bfha_pkg;
	localparam int unsigned HEAP_BYTES = 32768;
	localparam int unsigned MAX_BLOCKS = 32;
	localparam int unsigned AW = $clog2(HEAP_BYTES);      // offset bits
	localparam int unsigned LW = $clog2(HEAP_BYTES) + 1;  // length bits
	localparam int unsigned IW = $clog2(MAX_BLOCKS);      // index bits
	localparam int unsigned CW = $clog2(MAX_BLOCKS) + 1;  // count bits
	localparam int unsigned GW = LW + 1;                  // gap/compare bits

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_SPACE   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic          req_type;
		logic [15:0]   request_bytes;
		logic [14:0]   block_offset;
	} in_word_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [14:0]   granted_offset;
		logic [15:0]   bytes_used;
	} out_word_t;

	// One table entry.
	typedef struct packed {
		logic [AW-1:0] start;
		logic [LW-1:0] len;
	} entry_t;

	// Command from the sequencer to every cell.
	typedef struct packed {
		logic          scan;     // shift contents one cell toward the head
		logic          ins;      // insert new entry at pos
		logic          del;      // delete entry at pos
		logic [IW-1:0] pos;
		entry_t        new_e;
	} cell_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/bfha_cell.sv -----
// One table cell: holds an entry, rotates during scans, shifts on insert/delete.
`default_nettype none
module bfha_cell (
	input  wire logic                  clk,
	input  wire logic [bfha_pkg::IW-1:0] idx,
	input  wire bfha_pkg::cell_cmd_t   cmd,
	input  wire bfha_pkg::entry_t      from_next,  // neighbor above
	input  wire bfha_pkg::entry_t      from_prev,  // neighbor below
	output bfha_pkg::entry_t           entry
);
	bfha_pkg::entry_t e_q;
	assign entry = e_q;

	// scan rotates toward cell 0; insert pushes up; delete pulls down
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			e_q <= from_next;
		end else if (cmd.ins) begin
			if (idx == cmd.pos) e_q <= cmd.new_e;
			else if (idx > cmd.pos) e_q <= from_prev;
		end else if (cmd.del) begin
			if (idx >= cmd.pos) e_q <= from_next;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/best_fit_heap_allocator.sv -----
// Top level: request sequencer driving a ring of table cells.
//  channel | dir | valid | stall | word
//  req     | in  | req_valid | req_stall | bfha_pkg::in_word_t
//  rsp     | out | rsp_valid | rsp_stall | bfha_pkg::out_word_t
// A request scans the ring once, rotating every entry through cell 0, then passes
// through one update state and one result state.
// Early refusals (zero size, overflow, full) skip the scan and go straight to the result.
// The result sits in an output register; the next request is taken once
// the result is handed off. Reset clears count, byte total and control only.
`default_nettype none
module best_fit_heap_allocator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire bfha_pkg::in_word_t  req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output bfha_pkg::out_word_t      rsp
);
	localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_UPD = 2'd2, S_OUT = 2'd3;
	localparam int unsigned N = bfha_pkg::MAX_BLOCKS;

	logic [1:0]                st_q;
	logic [bfha_pkg::CW-1:0]   count_q;
	logic [bfha_pkg::LW-1:0]   used_q;
	bfha_pkg::in_word_t        req_q;
	logic [bfha_pkg::CW-1:0]   step_q;      // entry index currently at cell 0
	logic [bfha_pkg::LW:0]     prev_end_q;  // end of previous entry
	logic                      found_q;
	logic [bfha_pkg::IW-1:0]   best_pos_q;
	logic [bfha_pkg::GW-1:0]   best_left_q;
	logic [bfha_pkg::AW-1:0]   best_off_q;
	logic [bfha_pkg::LW-1:0]   free_len_q;
	bfha_pkg::cell_cmd_t       cmd;
	bfha_pkg::entry_t          ent [N];

	// cell ring
	for (genvar g = 0; g < N; g++) begin : g_cell
		bfha_cell u_cell (
			.clk(clk), .idx(bfha_pkg::IW'(g)), .cmd(cmd),
			.from_next(ent[(g + 1) % N]), .from_prev(ent[(g + N - 1) % N]),
			.entry(ent[g]));
	end

	// gap in front of the entry at cell 0 (or heap end when step reaches count)
	logic                      at_end;
	logic [bfha_pkg::LW:0]     hi;
	logic [bfha_pkg::GW-1:0]   gap, left;
	logic                      fits;
	always_comb begin
		at_end = (step_q == count_q);
		hi     = at_end ? (bfha_pkg::LW + 1)'(bfha_pkg::HEAP_BYTES)
			: (bfha_pkg::LW + 1)'(ent[0].start);
		gap    = (hi > prev_end_q) ? bfha_pkg::GW'(hi - prev_end_q) : '0;
		fits   = gap >= bfha_pkg::GW'(req_q.request_bytes);
		left   = gap - bfha_pkg::GW'(req_q.request_bytes);
	end

	logic [bfha_pkg::LW:0] total;
	assign total = (bfha_pkg::LW + 1)'(used_q) + (bfha_pkg::LW + 1)'(req.request_bytes);

	always_comb begin
		cmd = '0;
		cmd.scan = (st_q == S_SCAN);
		cmd.pos = best_pos_q;
		cmd.new_e.start = best_off_q;
		cmd.new_e.len = bfha_pkg::LW'(req_q.request_bytes);
		if (st_q == S_UPD && found_q) begin
			cmd.ins = (req_q.req_type == bfha_pkg::REQ_ALLOC);
			cmd.del = (req_q.req_type == bfha_pkg::REQ_FREE);
		end
	end

	assign req_stall = (st_q != S_IDLE);
	assign rsp_valid = (st_q == S_OUT);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			count_q <= '0;
			used_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (req_valid) begin
					req_q <= req;
					step_q <= '0;
					prev_end_q <= '0;
					found_q <= 1'b0;
					best_pos_q <= '0;
					best_left_q <= '0;
					best_off_q <= '0;
					free_len_q <= '0;
					rsp.granted_offset <= '0;
					st_q <= S_SCAN;
					if (req.req_type == bfha_pkg::REQ_ALLOC) begin
						priority if (req.request_bytes == '0) begin
							rsp.status <= bfha_pkg::ST_ZERO_SIZE; st_q <= S_OUT;
						end else if (total > (bfha_pkg::LW + 1)'(bfha_pkg::HEAP_BYTES)) begin
							rsp.status <= bfha_pkg::ST_NO_SPACE; st_q <= S_OUT;
						end else if (count_q >= bfha_pkg::CW'(N)) begin
							rsp.status <= bfha_pkg::ST_TABLE_FULL; st_q <= S_OUT;
						end else begin
						end
					end
					rsp.bytes_used <= used_q;
				end
				S_SCAN: begin
					if (req_q.req_type == bfha_pkg::REQ_ALLOC) begin
						if (step_q <= count_q && fits && (!found_q || left < best_left_q)) begin
							found_q <= 1'b1;
							best_left_q <= left;
							best_pos_q <= bfha_pkg::IW'(step_q);
							best_off_q <= bfha_pkg::AW'(prev_end_q);
						end
					end else if (step_q < count_q && !found_q
						&& ent[0].start == req_q.block_offset) begin
						found_q <= 1'b1;
						best_pos_q <= bfha_pkg::IW'(step_q);
						free_len_q <= ent[0].len;
					end
					prev_end_q <= (bfha_pkg::LW + 1)'(ent[0].start)
						+ (bfha_pkg::LW + 1)'(ent[0].len);
					step_q <= step_q + 1'b1;
					if (step_q == bfha_pkg::CW'(N - 1)) st_q <= S_UPD;
				end
				S_UPD: begin
					st_q <= S_OUT;
					if (!found_q) begin
						rsp.status <= (req_q.req_type == bfha_pkg::REQ_ALLOC)
							? bfha_pkg::ST_NO_SPACE : bfha_pkg::ST_NOT_FOUND;
					end else if (req_q.req_type == bfha_pkg::REQ_ALLOC) begin
						count_q <= count_q + 1'b1;
						used_q <= used_q + bfha_pkg::LW'(req_q.request_bytes);
						rsp.status <= bfha_pkg::ST_OK;
						rsp.granted_offset <= best_off_q;
						rsp.bytes_used <= used_q + bfha_pkg::LW'(req_q.request_bytes);
					end else begin
						count_q <= count_q - 1'b1;
						used_q <= (used_q >= free_len_q) ? used_q - free_len_q : '0;
						rsp.status <= bfha_pkg::ST_OK;
						rsp.bytes_used <= (used_q >= free_len_q) ? used_q - free_len_q : '0;
					end
				end
				S_OUT: if (!rsp_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// block count and bytes in use stay in range; the count changes only in the update state
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bfha_pkg::CW'(N)) else $error("block count out of range");
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= bfha_pkg::LW'(bfha_pkg::HEAP_BYTES)) else $error("bytes in use too large");
	a_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_UPD) |=> $stable(count_q)) else $error("count changed outside update");
endmodule
`default_nettype wire
